/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ACRLE_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked assertion that also runs during reset
`define ACRLE_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/acrle_pkg.sv */
// types and constants of the animation channel run-length decoder
package acrle_pkg;

	localparam int NUM_CHANNELS_DEF = 7;

	localparam int BYTE_W   = 8;
	localparam int CH_W     = 3;
	localparam int FRAME_W  = 16;
	localparam int LEN_W    = 7;
	localparam int SAMPLE_W = 16;
	localparam int OUT_DATA_W = 48;

	// run header layout
	localparam logic [BYTE_W-1:0] HDR_REPEAT_MASK = 8'h80;
	localparam logic [BYTE_W-1:0] HDR_COUNT_MASK  = 8'h7f;

	// parser phases, one-hot
	typedef enum logic [7:0] {
		PH_SIZE_LO = 8'b0000_0001,
		PH_SIZE_HI = 8'b0000_0010,
		PH_BUD_LO  = 8'b0000_0100,
		PH_BUD_HI  = 8'b0000_1000,
		PH_HEAD    = 8'b0001_0000,
		PH_STEP    = 8'b0010_0000,
		PH_VAL_LO  = 8'b0100_0000,
		PH_VAL_HI  = 8'b1000_0000
	} phase_t;

	// one decoded result
	typedef struct packed {
		logic [CH_W-1:0]            channel;
		logic [FRAME_W-1:0]         start_frame;
		logic [LEN_W-1:0]           run_length;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       bone_done;
		logic                       frame_overflow;
	} result_t;

	// parser status toward the pipeline control
	typedef struct packed {
		logic    valid;
		result_t res;
	} parse_out_t;

endpackage

/* rtl/acrle_parser.sv */
// byte parser: running record state and the result of the current byte
module acrle_parser #(
	parameter int NUM_CHANNELS = acrle_pkg::NUM_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [acrle_pkg::BYTE_W-1:0]      byte_in,
	input  logic [acrle_pkg::FRAME_W-1:0]     frame_count,
	output acrle_pkg::parse_out_t             pout
);

	localparam int CMP_W = acrle_pkg::CH_W + 1;
	localparam logic [CMP_W-1:0] LAST_CMP = CMP_W'(NUM_CHANNELS);

	acrle_pkg::phase_t                  phase_q, phase_d;
	logic [acrle_pkg::CH_W-1:0]         ch_q, ch_d;
	logic [acrle_pkg::FRAME_W-1:0]      frame_q, frame_d;
	logic [acrle_pkg::FRAME_W-1:0]      bud_q, bud_d;
	logic [acrle_pkg::LEN_W-1:0]        rr_q, rr_d;
	logic                               rep_q, rep_d;
	logic [acrle_pkg::BYTE_W-1:0]       hold_q, hold_d;

	logic                               is_last;
	logic                               fin;
	logic                               adv;
	logic [acrle_pkg::FRAME_W-1:0]      new_bud;
	logic [acrle_pkg::LEN_W-1:0]        rr_dec;
	logic [acrle_pkg::FRAME_W:0]        adv_sum;
	logic [acrle_pkg::FRAME_W:0]        end_sum;
	logic [acrle_pkg::SAMPLE_W-1:0]     word;

	assign is_last = ({1'b0, ch_q} + CMP_W'(1)) >= LAST_CMP;
	assign word    = {byte_in, hold_q};
	assign rr_dec  = rr_q - acrle_pkg::LEN_W'(1);
	assign new_bud = (acrle_pkg::FRAME_W'(byte_in) >= bud_q) ? '0
		: bud_q - acrle_pkg::FRAME_W'(byte_in);

	// next state and result of the byte in the input stage
	always_comb begin
		phase_d = phase_q;
		ch_d    = ch_q;
		frame_d = frame_q;
		bud_d   = bud_q;
		rr_d    = rr_q;
		rep_d   = rep_q;
		hold_d  = hold_q;
		fin     = 1'b0;
		adv     = 1'b0;
		pout.valid              = 1'b0;
		pout.res.channel        = ch_q;
		pout.res.start_frame    = frame_q;
		pout.res.run_length     = '0;
		pout.res.sample_value   = '0;
		pout.res.bone_done      = 1'b0;
		pout.res.frame_overflow = 1'b0;
		case (phase_q)
			acrle_pkg::PH_SIZE_LO: begin
				ch_d    = '0;
				phase_d = acrle_pkg::PH_SIZE_HI;
			end
			acrle_pkg::PH_SIZE_HI: begin
				phase_d = acrle_pkg::PH_BUD_LO;
			end
			acrle_pkg::PH_BUD_LO: begin
				hold_d  = byte_in;
				phase_d = acrle_pkg::PH_BUD_HI;
			end
			acrle_pkg::PH_BUD_HI: begin
				bud_d   = word;
				frame_d = '0;
				pout.res.start_frame = '0;
				if (word == '0) begin
					// empty channel marker
					pout.valid         = 1'b1;
					pout.res.bone_done = is_last;
					fin                = 1'b1;
				end else begin
					phase_d = acrle_pkg::PH_HEAD;
				end
			end
			acrle_pkg::PH_HEAD: begin
				rep_d   = |(byte_in & acrle_pkg::HDR_REPEAT_MASK);
				rr_d    = acrle_pkg::LEN_W'(byte_in & acrle_pkg::HDR_COUNT_MASK);
				phase_d = acrle_pkg::PH_STEP;
			end
			acrle_pkg::PH_STEP: begin
				bud_d = new_bud;
				if (!rep_q && rr_q == '0) begin
					// empty literal run: marker only if it closes the channel
					if (new_bud == '0) begin
						pout.valid         = 1'b1;
						pout.res.bone_done = is_last;
					end
					fin = 1'b1;
				end else begin
					phase_d = acrle_pkg::PH_VAL_LO;
				end
			end
			acrle_pkg::PH_VAL_LO: begin
				hold_d  = byte_in;
				phase_d = acrle_pkg::PH_VAL_HI;
			end
			acrle_pkg::PH_VAL_HI: begin
				pout.valid            = 1'b1;
				pout.res.sample_value = word;
				adv                   = 1'b1;
				if (rep_q) begin
					pout.res.run_length = rr_q;
					pout.res.bone_done  = (bud_q == '0) && is_last;
					rr_d                = '0;
					fin                 = 1'b1;
				end else begin
					pout.res.run_length = acrle_pkg::LEN_W'(1);
					rr_d                = rr_dec;
					if (rr_dec == '0) begin
						pout.res.bone_done = (bud_q == '0) && is_last;
						fin                = 1'b1;
					end else begin
						phase_d = acrle_pkg::PH_VAL_LO;
					end
				end
			end
			default: begin
				phase_d = acrle_pkg::PH_SIZE_LO;
			end
		endcase

		// overflow of the covered frame range
		end_sum = {1'b0, pout.res.start_frame}
			+ (acrle_pkg::FRAME_W + 1)'(pout.res.run_length);
		pout.res.frame_overflow = end_sum > {1'b0, frame_count};

		// saturating frame advance
		adv_sum = {1'b0, frame_q} + (acrle_pkg::FRAME_W + 1)'(pout.res.run_length);
		if (adv) begin
			frame_d = adv_sum[acrle_pkg::FRAME_W] ? '1
				: adv_sum[acrle_pkg::FRAME_W-1:0];
		end

		// end of run: next run, next channel or next record
		if (fin) begin
			if (bud_d != '0) begin
				phase_d = acrle_pkg::PH_HEAD;
			end else if (is_last) begin
				ch_d    = '0;
				phase_d = acrle_pkg::PH_SIZE_LO;
			end else begin
				ch_d    = ch_q + acrle_pkg::CH_W'(1);
				phase_d = acrle_pkg::PH_BUD_LO;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acrle_pkg::PH_SIZE_LO;
			ch_q    <= '0;
			frame_q <= '0;
			bud_q   <= '0;
			rr_q    <= '0;
			rep_q   <= 1'b0;
			hold_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ch_q    <= ch_d;
			frame_q <= frame_d;
			bud_q   <= bud_d;
			rr_q    <= rr_d;
			rep_q   <= rep_d;
			hold_q  <= hold_d;
		end
	end

endmodule

/* rtl/acrle_out_reg.sv */
// result register in front of the output stream
module acrle_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  acrle_pkg::result_t  res,
	input  logic                take,
	output logic                free,
	output logic                valid,
	output acrle_pkg::result_t  res_q
);

	logic valid_q;

	assign valid = valid_q;
	assign free  = !valid_q || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

/* rtl/animation_channel_rle_decoder.sv */
// top level of the animation channel run-length decoder
// Decodes a bone animation record one byte per beat: size word, then per channel a
// 16-bit budget and runs of header, step and 16-bit values. Each repeat run and each
// literal value gives one result beat; an empty channel gives a marker with length 0.
// A byte is taken every cycle while s_tready is high; a byte is registered in the input
// register and its result, if any, is loaded into the output register when the input
// stage advances. s_tready drops only while a result waits in the output register and the
// byte in the input register would produce another one. The user must write frame_count
// on the cfg channel only between records; the block itself does not enforce it.
module animation_channel_rle_decoder #(
	parameter int NUM_CHANNELS = acrle_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: frame_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // channel[2:0], start_frame[18:3],
	                               // run_length[25:19], sample_value[41:26], zero pad
	output logic        m_tlast,   // bone_done
	output logic        m_tuser    // frame_overflow
);

	logic [acrle_pkg::FRAME_W-1:0] frame_count_q;
	logic [acrle_pkg::BYTE_W-1:0]  byte_s1;
	logic                          valid_s1;
	logic                          advance;
	logic                          out_free;
	acrle_pkg::parse_out_t         pout;
	acrle_pkg::result_t            res_q;

	assign cfg_ready = 1'b1;

	// frame count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (cfg_valid) begin
			frame_count_q <= cfg_data;
		end
	end

	// input stage moves on unless its result finds the output register full
	assign advance  = valid_s1 && (!pout.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	acrle_parser #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.byte_in     (byte_s1),
		.frame_count (frame_count_q),
		.pout        (pout)
	);

	acrle_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && pout.valid),
		.res    (pout.res),
		.take   (m_tready),
		.free   (out_free),
		.valid  (m_tvalid),
		.res_q  (res_q)
	);

	// output beat packing
	assign m_tdata = {6'd0, res_q.sample_value, res_q.run_length,
		res_q.start_frame, res_q.channel};
	assign m_tlast = res_q.bone_done;
	assign m_tuser = res_q.frame_overflow;

endmodule

/* rtl/acrle_checker.sv */
// port-level checker for the decoder and its bind
`include "assert_macros.svh"

module acrle_checker #(
	parameter int NUM_CHANNELS = acrle_pkg::NUM_CHANNELS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

	logic [15:0] fc_q;
	logic [16:0] end_sum;

	// shadow of the frame count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			fc_q <= cfg_data;
		end
	end

	assign end_sum = {1'b0, m_tdata[18:3]} + 17'(m_tdata[25:19]);

	`ACRLE_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result beat changed while stalled")
	`ACRLE_ASSERT(a_ch_range, clk, arst_n, m_tvalid |-> {1'b0, m_tdata[2:0]} <= LAST_CH, "channel beyond last channel")
	`ACRLE_ASSERT(a_last_ch, clk, arst_n, m_tvalid && m_tlast |-> {1'b0, m_tdata[2:0]} == LAST_CH, "bone done on a channel that is not the last")
	`ACRLE_ASSERT(a_ovf, clk, arst_n, m_tvalid |-> m_tuser == (end_sum > {1'b0, fc_q}), "overflow flag disagrees with frame count")

endmodule

bind animation_channel_rle_decoder acrle_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_acrle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_data  (cfg_data),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.m_tuser   (m_tuser)
);

/* dv/tb_top.sv */
// testbench for the animation channel run-length decoder: directed and random byte streams
module tb_top;

	localparam int NUM_CH = acrle_pkg::NUM_CHANNELS_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	// decoder state as the stream is parsed
	acrle_pkg::phase_t dec_phase = acrle_pkg::PH_SIZE_LO;
	logic [2:0]  dec_chan = '0;
	logic [15:0] dec_frame = '0;
	logic [15:0] dec_budget = '0;
	logic [6:0]  dec_run_left = '0;
	logic        dec_repeat = 1'b0;
	logic [7:0]  dec_lo_hold = '0;
	logic [15:0] frame_limit = '0;

	acrle_pkg::result_t expected_samples[$];
	acrle_pkg::result_t got_sample;
	acrle_pkg::result_t want_sample;
	int unsigned fail_count = 0;
	int unsigned report_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned cut_at = 0;
	int          hold_len = 0;
	bit          src_idle_en = 1'b1;
	bit          sink_idle_en = 1'b1;

	animation_channel_rle_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic bit on_last_channel();
		return (int'(dec_chan) + 1) >= NUM_CH;
	endfunction

	function automatic bit ends_bone();
		return (dec_budget == 16'h0) && on_last_channel();
	endfunction

	function automatic void log_sample(input int unsigned len, input logic [15:0] value,
			input logic done);
		acrle_pkg::result_t r;
		r.channel        = dec_chan;
		r.start_frame    = dec_frame;
		r.run_length     = len[6:0];
		r.sample_value   = value;
		r.bone_done      = done;
		r.frame_overflow = (32'(dec_frame) + len) > 32'(frame_limit);
		expected_samples = {expected_samples, r};
	endfunction

	// frame position saturates instead of wrapping
	function automatic void skip_frames(input int unsigned len);
		int unsigned f;
		f = 32'(dec_frame) + len;
		dec_frame = (f > 32'hffff) ? 16'hffff : f[15:0];
	endfunction

	function automatic void end_run();
		if (dec_budget != 16'h0) begin
			dec_phase = acrle_pkg::PH_HEAD;
		end else if (on_last_channel()) begin
			dec_chan  = '0;
			dec_phase = acrle_pkg::PH_SIZE_LO;
		end else begin
			dec_chan  = dec_chan + 3'd1;
			dec_phase = acrle_pkg::PH_BUD_LO;
		end
	endfunction

	// advance the parser by one accepted byte and queue any result it yields
	function automatic void decode_byte(input logic [7:0] b);
		logic [15:0] word;
		word = {b, dec_lo_hold};
		case (dec_phase)
			acrle_pkg::PH_SIZE_LO: begin
				dec_chan  = '0;
				dec_phase = acrle_pkg::PH_SIZE_HI;
			end
			acrle_pkg::PH_SIZE_HI: dec_phase = acrle_pkg::PH_BUD_LO;
			acrle_pkg::PH_BUD_LO: begin
				dec_lo_hold = b;
				dec_phase   = acrle_pkg::PH_BUD_HI;
			end
			acrle_pkg::PH_BUD_HI: begin
				dec_budget = word;
				dec_frame  = '0;
				if (dec_budget == 16'h0) begin
					log_sample(0, 16'h0, ends_bone());
					end_run();
				end else begin
					dec_phase = acrle_pkg::PH_HEAD;
				end
			end
			acrle_pkg::PH_HEAD: begin
				dec_repeat   = b[7];
				dec_run_left = b[6:0];
				dec_phase    = acrle_pkg::PH_STEP;
			end
			acrle_pkg::PH_STEP: begin
				// underflow clamps the budget to zero
				dec_budget = (16'(b) >= dec_budget) ? 16'h0 : dec_budget - 16'(b);
				if (!dec_repeat && dec_run_left == 7'd0) begin
					if (dec_budget == 16'h0)
						log_sample(0, 16'h0, ends_bone());
					end_run();
				end else begin
					dec_phase = acrle_pkg::PH_VAL_LO;
				end
			end
			acrle_pkg::PH_VAL_LO: begin
				dec_lo_hold = b;
				dec_phase   = acrle_pkg::PH_VAL_HI;
			end
			default: begin
				if (dec_repeat) begin
					log_sample(32'(dec_run_left), word, ends_bone());
					skip_frames(32'(dec_run_left));
					dec_run_left = '0;
					end_run();
				end else begin
					dec_run_left = dec_run_left - 7'd1;
					if (dec_run_left == 7'd0) begin
						log_sample(1, word, ends_bone());
						skip_frames(1);
						end_run();
					end else begin
						// more values follow, so this one cannot end the bone
						log_sample(1, word, 1'b0);
						skip_frames(1);
						dec_phase = acrle_pkg::PH_VAL_LO;
					end
				end
			end
		endcase
	endfunction

	// offer one byte, with an optional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic send_list(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// drive the parser to a record boundary by the shortest path
	task automatic finish_record();
		logic [7:0] b;
		while (dec_phase != acrle_pkg::PH_SIZE_LO) begin
			case (dec_phase)
				acrle_pkg::PH_HEAD:   b = 8'h00;
				acrle_pkg::PH_STEP:   b = 8'hff;
				acrle_pkg::PH_VAL_LO,
				acrle_pkg::PH_VAL_HI: b = 8'($urandom_range(0, 255));
				default:              b = 8'h00;
			endcase
			send_byte(b);
		end
	endtask

	// stop offering and let every pending result drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_frame_count(input logic [15:0] v);
		finish_record();
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		frame_limit = v;
	endtask

	task automatic send_random_run();
		logic [7:0] hdr;
		logic [7:0] step;
		int         kind;
		kind = $urandom_range(0, 9);
		step = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
		                                   : 8'($urandom_range(0, 12));
		if (kind < 4)
			hdr = 8'h80 | (($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
			                                           : 8'($urandom_range(0, 8)));
		else if (kind < 9)
			hdr = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(5, 127))
			                                   : 8'($urandom_range(1, 4));
		else
			hdr = 8'h00;
		send_byte(hdr);
		send_byte(step);
		while (dec_phase == acrle_pkg::PH_VAL_LO || dec_phase == acrle_pkg::PH_VAL_HI) begin
			if (cut_at != 0 && bytes_sent >= cut_at)
				return;
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// well-formed record with random content, optionally cut short
	task automatic send_random_record(input bit truncate);
		logic [15:0] budget;
		int          pick;
		finish_record();
		cut_at = truncate ? bytes_sent + $urandom_range(3, 80) : 0;
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
		for (int c = 0; c < NUM_CH; c++) begin
			if (cut_at != 0 && bytes_sent >= cut_at)
				return;
			pick = $urandom_range(0, 19);
			if (pick < 3)
				budget = 16'h0;
			else if (pick == 3)
				budget = 16'($urandom_range(256, 1500));
			else
				budget = 16'($urandom_range(1, 40));
			send_byte(budget[7:0]);
			send_byte(budget[15:8]);
			while (dec_phase == acrle_pkg::PH_HEAD) begin
				if (cut_at != 0 && bytes_sent >= cut_at)
					return;
				send_random_run();
			end
		end
	endtask

	// result sink ready, with random stalls and long hold-offs on request
	initial begin : sink_ready
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_sample.channel        = m_tdata[2:0];
			got_sample.start_frame    = m_tdata[18:3];
			got_sample.run_length     = m_tdata[25:19];
			got_sample.sample_value   = m_tdata[41:26];
			got_sample.bone_done      = m_tlast;
			got_sample.frame_overflow = m_tuser;
			if (expected_samples.size() == 0) begin
				fail_count++;
				report_count++;
				if (report_count <= 10)
					$display("unexpected: ch %0d start %0d len %0d val %0d done %0b ovf %0b",
						got_sample.channel, got_sample.start_frame, got_sample.run_length,
						got_sample.sample_value, got_sample.bone_done, got_sample.frame_overflow);
			end else begin
				want_sample = expected_samples.pop_front();
				if (got_sample.channel !== want_sample.channel ||
						got_sample.start_frame !== want_sample.start_frame ||
						got_sample.run_length !== want_sample.run_length ||
						got_sample.sample_value !== want_sample.sample_value ||
						got_sample.bone_done !== want_sample.bone_done ||
						got_sample.frame_overflow !== want_sample.frame_overflow) begin
					fail_count++;
					report_count++;
					if (report_count <= 10) begin
						$display("mismatch: exp ch %0d start %0d len %0d val %0d done %0b ovf %0b",
							want_sample.channel, want_sample.start_frame, want_sample.run_length,
							want_sample.sample_value, want_sample.bone_done,
							want_sample.frame_overflow);
						$display("          got ch %0d start %0d len %0d val %0d done %0b ovf %0b",
							got_sample.channel, got_sample.start_frame, got_sample.run_length,
							got_sample.sample_value, got_sample.bone_done,
							got_sample.frame_overflow);
					end
				end
			end
		end
	end

	// a record of empty channels gives one marker per channel
	task automatic test_empty_channels();
		send_list({8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
	endtask

	// longest repeat, values at the sample extremes, zero-count runs, underflow
	task automatic test_run_forms();
		set_frame_count(16'd10);
		send_list({8'h34, 8'h12, 8'h00, 8'h01,
			8'hff, 8'h00, 8'h00, 8'h80,
			8'h02, 8'h7f, 8'hff, 8'h7f, 8'hff, 8'hff,
			8'h80, 8'h01, 8'h01, 8'h00,
			8'h00, 8'h00,
			8'h01, 8'hff, 8'h55, 8'haa});
		finish_record();
	endtask

	// zero-count literal closing the last channel marks the bone end
	task automatic test_last_channel_marker();
		send_list({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h03, 8'h00, 8'h83, 8'h01, 8'h10, 8'h00, 8'h00, 8'h05});
	endtask

	// long repeat runs carry the frame position well past the frame count
	task automatic test_long_runs();
		set_frame_count(16'd3000);
		send_list({8'h00, 8'h00, 8'h28, 8'h00});
		repeat (40) begin
			send_byte(8'hff);
			send_byte(8'h01);
			send_byte(8'($urandom_range(0, 255)));
			send_byte(8'($urandom_range(0, 255)));
		end
		finish_record();
	endtask

	// hold the sink off while a long literal run keeps arriving, then pause the source
	task automatic test_backpressure();
		set_frame_count(16'd200);
		src_idle_en = 1'b0;
		hold_len = 400;
		send_list({8'h00, 8'h00, 8'h1e, 8'h00, 8'h7f, 8'h01});
		send_noise(254);
		finish_record();
		wait_idle();
		src_idle_en = 1'b1;
	endtask

	// random records, cut records and noise under several frame counts
	task automatic test_random_records();
		logic [15:0] limits[6];
		int unsigned start;
		int          pick;
		limits = '{16'd0, 16'hffff, 16'd24, 16'd1, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 600))};
		foreach (limits[i]) begin
			set_frame_count(limits[i]);
			src_idle_en  = $urandom_range(0, 1);
			sink_idle_en = $urandom_range(0, 1);
			start = bytes_sent;
			while (bytes_sent - start < 120) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					send_random_record(1'b0);
				end else if (pick < 9) begin
					send_random_record(1'b1);
					send_noise($urandom_range(1, 20));
				end else begin
					send_noise($urandom_range(5, 30));
				end
			end
		end
		cut_at = 0;
	endtask

	// closing stretch with both sides always ready
	task automatic test_quiet_tail();
		set_frame_count(16'd48);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (3) send_random_record(1'b0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_channels();
		test_run_forms();
		test_last_channel_marker();
		test_long_runs();
		test_backpressure();
		test_random_records();
		test_quiet_tail();
		s_tvalid <= 1'b0;
		for (int i = 0; i < 5000 && expected_samples.size() != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		fail_count += expected_samples.size();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
